/* rtl/bha_pkg.sv */
`default_nettype none

package bha_pkg;

  localparam int MAX_LEN  = 255;
  localparam int ALPHABET = 256;
  localparam int SLOT_W   = $clog2(ALPHABET);
  localparam int COUNT_W  = 8;
  localparam int LEN_W    = $clog2(MAX_LEN + 2);

  localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(MAX_LEN + 1);
  localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(MAX_LEN);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] FOLD_OFS = 8'h20;

  typedef enum logic {
    KIND_FIRST  = 1'b0,
    KIND_SECOND = 1'b1
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
  } tally_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tally_stat_t;

endpackage

`default_nettype wire

/* rtl/byte_histogram_anagram_check.sv */
`default_nettype none

// Anagram check over two byte words. Send the bytes of the first word with kind low, then
// the bytes of the second word with kind high, and mark the final byte of the second word
// with last; one result beat follows, and all counts are then cleared for the next pair.
// The block takes one byte per cycle: each byte makes one read-modify-write of its count in
// a 256-entry counter memory, with a bypass between back-to-back bytes of the same value.
// The last byte is registered before the result beat is. While a result beat is
// stalled, the last byte of the following pair is held back. With case_sensitive low,
// ASCII upper-case letters count as lower case. Write case_sensitive only while idle.
module byte_histogram_anagram_check (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_anagram,
  output logic            too_long
);

  logic                           case_sensitive;
  logic [7:0]                     code_fold;
  logic                           accept;
  logic                           adv;
  logic                           result;
  logic                           s1_last;
  bha_pkg::tally_op_t             op;
  bha_pkg::tally_stat_t           stat;
  logic [bha_pkg::LEN_W-1:0]      first_length;
  logic [bha_pkg::LEN_W-1:0]      second_length;
  logic [bha_pkg::LEN_W-1:0]      first_length_next;
  logic [bha_pkg::LEN_W-1:0]      second_length_next;
  logic                           mismatch_seen;
  logic                           overflow_seen;
  logic                           mismatch_next;
  logic                           overflow_next;

  always_comb begin
    code_fold = char_code;
    if (!case_sensitive && char_code >= bha_pkg::UPPER_A && char_code <= bha_pkg::UPPER_Z) begin
      code_fold = char_code + bha_pkg::FOLD_OFS;
    end
  end

  assign adv      = !(op.valid && op.kind == bha_pkg::KIND_SECOND && s1_last &&
                      out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign result   = op.valid && adv && op.kind == bha_pkg::KIND_SECOND && s1_last;

  bha_tally u_tally (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_slot(code_fold[bha_pkg::SLOT_W-1:0]),
    .op     (op),
    .adv    (adv),
    .clear  (result),
    .stat   (stat)
  );

  always_comb begin
    first_length_next  = first_length;
    second_length_next = second_length;
    mismatch_next      = mismatch_seen;
    overflow_next      = overflow_seen;
    if (op.kind == bha_pkg::KIND_FIRST) begin
      if (first_length < bha_pkg::LEN_CAP) begin
        first_length_next = first_length + 1'b1;
      end
      if (first_length_next > bha_pkg::LEN_LIMIT || stat.full) begin
        overflow_next = 1'b1;
      end
    end else begin
      if (second_length < bha_pkg::LEN_CAP) begin
        second_length_next = second_length + 1'b1;
      end
      if (second_length_next > bha_pkg::LEN_LIMIT) begin
        overflow_next = 1'b1;
      end
      if (stat.empty) begin
        mismatch_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_sensitive <= 1'b1;
      op.valid       <= 1'b0;
      out_valid      <= 1'b0;
      first_length   <= '0;
      second_length  <= '0;
      mismatch_seen  <= 1'b0;
      overflow_seen  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case_sensitive <= cfg_wr_data;
      end
      if (adv) begin
        op.valid <= accept;
      end
      if (result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (result) begin
        first_length  <= '0;
        second_length <= '0;
        mismatch_seen <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (op.valid && adv) begin
        first_length  <= first_length_next;
        second_length <= second_length_next;
        mismatch_seen <= mismatch_next;
        overflow_seen <= overflow_next;
      end
    end
    if (accept) begin
      op.kind <= bha_pkg::kind_t'(kind);
      op.slot <= code_fold[bha_pkg::SLOT_W-1:0];
      s1_last <= last;
    end
    if (result) begin
      is_anagram <= !mismatch_next && !overflow_next &&
                    (first_length_next == second_length_next);
      too_long   <= overflow_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bha_ram.sv */
`default_nettype none

module bha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bha_tally.sv */
`default_nettype none

module bha_tally (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [bha_pkg::SLOT_W-1:0] rd_slot,
  input  wire bha_pkg::tally_op_t        op,
  input  wire logic                      adv,
  input  wire logic                      clear,
  output bha_pkg::tally_stat_t           stat
);

  logic [bha_pkg::COUNT_W-1:0]  rdata;
  logic [bha_pkg::COUNT_W-1:0]  cur;
  logic [bha_pkg::COUNT_W-1:0]  wdata;
  logic [bha_pkg::COUNT_W-1:0]  fwd_data;
  logic                         fwd_hit;
  logic [bha_pkg::ALPHABET-1:0] vld;
  logic                         wr_en;

  bha_ram #(
    .WIDTH(bha_pkg::COUNT_W),
    .DEPTH(bha_pkg::ALPHABET)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(op.slot),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_slot),
    .rdata(rdata)
  );

  // A count that was written in the same cycle as its read comes from the bypass.
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (vld[op.slot]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    stat.empty = (cur == '0);
    stat.full  = (cur == bha_pkg::COUNT_MAX);
    if (op.kind == bha_pkg::KIND_FIRST) begin
      wdata = stat.full ? cur : cur + 1'b1;
    end else begin
      wdata = stat.empty ? cur : cur - 1'b1;
    end
    wr_en = op.valid && adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en && clear) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[op.slot] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit <= wr_en && !clear && (op.slot == rd_slot);
      end
    end
    if (rd_en) begin
      fwd_data <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/bha_checker.sv */
`default_nettype none

module bha_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       kind,
  input wire logic       last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       is_anagram,
  input wire logic       too_long
);

  // A stalled result beat stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_anagram) && $stable(too_long))
    else $error("stalled result beat changed");

  // An oversized word can never pass as an anagram.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_anagram && too_long))
    else $error("anagram reported together with too_long");

  // A fresh result beat must follow an accepted last byte of a second word.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && kind && last, 2))
    else $error("result beat without a closing byte");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind byte_histogram_anagram_check bha_checker u_bha_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_anagram(is_anagram),
  .too_long  (too_long)
);

`default_nettype wire
